// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`endif

`ifndef SYNTHESIS
// Expression must never be true out of reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define ASSERT_NEVER(label, expr, msg)
`endif

`endif

// ===== rtl/ffha_pkg.sv =====
// Types, constants and state codes of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

    localparam int unsigned HEAP_BYTES    = 65536;
    localparam int unsigned TABLE_ENTRIES = 256;

    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned SIZE_W  = 17;
    localparam int unsigned BUMP_W  = $clog2(HEAP_BYTES + 1);
    localparam int unsigned SUM_W   = ((BUMP_W > SIZE_W) ? BUMP_W : SIZE_W) + 1;
    localparam int unsigned WIDE_W  = SIZE_W + 1;
    localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned ENTRY_W = ADDR_W + SIZE_W;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 24;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [BUMP_W-1:0] bump_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [WIDE_W-1:0] wide_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        addr_t start;
        size_t len;
    } tab_entry_t;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_FIT,
        OP_FIND,
        OP_MERGE,
        OP_WRITE
    } tab_op_t;

    typedef struct packed {
        logic       valid;
        tab_op_t    op;
        size_t      key;
        idx_t       idx;
        tab_entry_t entry;
    } tab_cmd_t;

    typedef struct packed {
        logic       done;
        logic       hit;
        idx_t       idx;
        tab_entry_t entry;
    } tab_rsp_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_INS,
        T_INS_LAST,
        T_REM,
        T_SCAN,
        T_MERGE_FIRST,
        T_MERGE,
        T_MERGE_END
    } tab_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_BUMP_INS,
        S_FIT,
        S_MERGE,
        S_FIT_INS,
        S_FIT_UPD,
        S_FIND,
        S_FREE_INS,
        S_USED_REM,
        S_DONE
    } alloc_state_t;

endpackage
`default_nettype wire

// ===== rtl/first_fit_heap_allocator_core.sv =====
// Top level of the first-fit heap allocator: request sequencer over two chunk tables.
//
//  channel | dir | tdata (low bit up)                   | tuser
//  s_      | in  | alloc_size[16:0], free_address[32:17] | kind (0 alloc, 1 free)
//  m_      | out | address[15:0], status[18:16]          | -
//
//  One request at a time. Bump allocate: the new start sorts last, so no shift is needed.
//  Fit allocate: free-table scan, optional merge pass and rescan, used insert and free
//  update, each one RAM entry per cycle. Free: used lookup, free insert and used remove.
//  Ready right after reset; tables need no clearing pass. A new request is taken while
//  the last response waits in the output register.
`default_nettype none
`include "assert_macros.svh"
module first_fit_heap_allocator_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ffha_pkg::S_TDATA_W-1:0] s_tdata,   // alloc_size, free_address
    input  logic                           s_tuser,   // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ffha_pkg::M_TDATA_W-1:0] m_tdata    // address, status
);

    ffha_pkg::alloc_state_t state_reg, state_next;
    logic                   kind_reg, kind_next;
    ffha_pkg::size_t        size_reg, size_next;
    ffha_pkg::addr_t        faddr_reg, faddr_next;
    ffha_pkg::bump_t        bump_reg, bump_next;
    logic                   retry_reg, retry_next;
    ffha_pkg::addr_t        addr_reg, addr_next;
    ffha_pkg::status_t      status_reg, status_next;
    ffha_pkg::idx_t         hit_idx_reg, hit_idx_next;
    ffha_pkg::tab_entry_t   hit_entry_reg, hit_entry_next;
    logic                   m_valid_reg, m_valid_next;
    ffha_pkg::addr_t        m_addr_reg, m_addr_next;
    ffha_pkg::status_t      m_status_reg, m_status_next;

    ffha_pkg::tab_cmd_t ucmd, fcmd;
    ffha_pkg::tab_rsp_t ursp, frsp;
    ffha_pkg::cnt_t     ucount, fcount;

    logic            s_accept, size_zero, used_full, free_full, bump_fits, out_free;
    ffha_pkg::sum_t  bump_sum;

    assign s_accept  = s_tvalid && s_tready;
    assign size_zero = (size_reg == '0);
    assign used_full = (ucount == ffha_pkg::cnt_t'(ffha_pkg::TABLE_ENTRIES));
    assign free_full = (fcount == ffha_pkg::cnt_t'(ffha_pkg::TABLE_ENTRIES));
    assign bump_sum  = ffha_pkg::sum_t'(bump_reg) + ffha_pkg::sum_t'(size_reg);
    assign bump_fits = (bump_sum <= ffha_pkg::sum_t'(ffha_pkg::HEAP_BYTES));
    assign out_free  = !m_valid_reg || m_tready;

    ffha_table u_used (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (ucmd),
        .rsp    (ursp),
        .count  (ucount)
    );

    ffha_table u_free (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (fcmd),
        .rsp    (frsp),
        .count  (fcount)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ffha_pkg::S_IDLE: if (s_accept) state_next = ffha_pkg::S_DECIDE;
            ffha_pkg::S_DECIDE: begin
                if (kind_reg == ffha_pkg::KIND_FREE) begin
                    state_next = ffha_pkg::S_FIND;
                end else if (size_zero || used_full) begin
                    state_next = ffha_pkg::S_DONE;
                end else if (bump_fits) begin
                    state_next = ffha_pkg::S_BUMP_INS;
                end else begin
                    state_next = ffha_pkg::S_FIT;
                end
            end
            ffha_pkg::S_BUMP_INS: if (ursp.done) state_next = ffha_pkg::S_DONE;
            ffha_pkg::S_FIT: begin
                if (frsp.done) begin
                    if (frsp.hit) begin
                        state_next = ffha_pkg::S_FIT_INS;
                    end else begin
                        state_next = retry_reg ? ffha_pkg::S_DONE : ffha_pkg::S_MERGE;
                    end
                end
            end
            ffha_pkg::S_MERGE:   if (frsp.done) state_next = ffha_pkg::S_FIT;
            ffha_pkg::S_FIT_INS: if (ursp.done) state_next = ffha_pkg::S_FIT_UPD;
            ffha_pkg::S_FIT_UPD: if (frsp.done) state_next = ffha_pkg::S_DONE;
            ffha_pkg::S_FIND: begin
                if (ursp.done) begin
                    state_next = (ursp.hit && !free_full) ? ffha_pkg::S_FREE_INS
                                                          : ffha_pkg::S_DONE;
                end
            end
            ffha_pkg::S_FREE_INS: if (frsp.done) state_next = ffha_pkg::S_USED_REM;
            ffha_pkg::S_USED_REM: if (ursp.done) state_next = ffha_pkg::S_DONE;
            ffha_pkg::S_DONE:     if (out_free) state_next = ffha_pkg::S_IDLE;
            default: state_next = ffha_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        ucmd           = '0;
        fcmd           = '0;
        s_tready       = (state_reg == ffha_pkg::S_IDLE);
        kind_next      = kind_reg;
        size_next      = size_reg;
        faddr_next     = faddr_reg;
        bump_next      = bump_reg;
        retry_next     = retry_reg;
        addr_next      = addr_reg;
        status_next    = status_reg;
        hit_idx_next   = hit_idx_reg;
        hit_entry_next = hit_entry_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_addr_next    = m_addr_reg;
        m_status_next  = m_status_reg;
        unique case (state_reg)
            ffha_pkg::S_IDLE: begin
                if (s_accept) begin
                    kind_next   = s_tuser;
                    size_next   = s_tdata[ffha_pkg::SIZE_W-1:0];
                    faddr_next  = s_tdata[ffha_pkg::SIZE_W +: ffha_pkg::ADDR_W];
                    retry_next  = 1'b0;
                    addr_next   = '0;
                    status_next = ffha_pkg::ST_OK;
                end
            end
            ffha_pkg::S_DECIDE: begin
                if (kind_reg == ffha_pkg::KIND_FREE) begin
                    ucmd.valid = 1'b1;
                    ucmd.op    = ffha_pkg::OP_FIND;
                    ucmd.key   = ffha_pkg::size_t'(faddr_reg);
                end else if (size_zero) begin
                    status_next = ffha_pkg::ST_ZERO;
                end else if (used_full) begin
                    status_next = ffha_pkg::ST_FULL;
                end else if (bump_fits) begin
                    ucmd.valid       = 1'b1;
                    ucmd.op          = ffha_pkg::OP_INSERT;
                    ucmd.entry.start = ffha_pkg::addr_t'(bump_reg);
                    ucmd.entry.len   = size_reg;
                    addr_next        = ffha_pkg::addr_t'(bump_reg);
                    bump_next        = ffha_pkg::bump_t'(bump_sum);
                end else begin
                    fcmd.valid = 1'b1;
                    fcmd.op    = ffha_pkg::OP_FIT;
                    fcmd.key   = size_reg;
                end
            end
            ffha_pkg::S_FIT: begin
                if (frsp.done) begin
                    if (frsp.hit) begin
                        hit_idx_next     = frsp.idx;
                        hit_entry_next   = frsp.entry;
                        addr_next        = frsp.entry.start;
                        ucmd.valid       = 1'b1;
                        ucmd.op          = ffha_pkg::OP_INSERT;
                        ucmd.entry.start = frsp.entry.start;
                        ucmd.entry.len   = size_reg;
                    end else if (retry_reg) begin
                        status_next = ffha_pkg::ST_NOSPACE;
                    end else begin
                        retry_next = 1'b1;
                        fcmd.valid = 1'b1;
                        fcmd.op    = ffha_pkg::OP_MERGE;
                    end
                end
            end
            ffha_pkg::S_MERGE: begin
                if (frsp.done) begin
                    fcmd.valid = 1'b1;
                    fcmd.op    = ffha_pkg::OP_FIT;
                    fcmd.key   = size_reg;
                end
            end
            ffha_pkg::S_FIT_INS: begin
                if (ursp.done) begin
                    fcmd.valid = 1'b1;
                    fcmd.idx   = hit_idx_reg;
                    if (hit_entry_reg.len == size_reg) begin
                        fcmd.op = ffha_pkg::OP_REMOVE;
                    end else begin
                        // chunk shrinks from its low end
                        fcmd.op          = ffha_pkg::OP_WRITE;
                        fcmd.entry.start = hit_entry_reg.start + ffha_pkg::addr_t'(size_reg);
                        fcmd.entry.len   = hit_entry_reg.len - size_reg;
                    end
                end
            end
            ffha_pkg::S_FIND: begin
                if (ursp.done) begin
                    if (!ursp.hit) begin
                        status_next = ffha_pkg::ST_NOTFOUND;
                    end else if (free_full) begin
                        status_next = ffha_pkg::ST_FULL;
                    end else begin
                        hit_idx_next = ursp.idx;
                        fcmd.valid   = 1'b1;
                        fcmd.op      = ffha_pkg::OP_INSERT;
                        fcmd.entry   = ursp.entry;
                    end
                end
            end
            ffha_pkg::S_FREE_INS: begin
                if (frsp.done) begin
                    ucmd.valid = 1'b1;
                    ucmd.op    = ffha_pkg::OP_REMOVE;
                    ucmd.idx   = hit_idx_reg;
                end
            end
            ffha_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_addr_next   = (status_reg == ffha_pkg::ST_OK) ? addr_reg : '0;
                    m_status_next = status_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffha_pkg::S_IDLE;
            bump_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bump_reg    <= bump_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        size_reg      <= size_next;
        faddr_reg     <= faddr_next;
        retry_reg     <= retry_next;
        addr_reg      <= addr_next;
        status_reg    <= status_next;
        hit_idx_reg   <= hit_idx_next;
        hit_entry_reg <= hit_entry_next;
        m_addr_reg    <= m_addr_next;
        m_status_reg  <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_status_reg, m_addr_reg};

    `ASSERT_PROP(a_bump_bound, ffha_pkg::sum_t'(bump_reg) <= ffha_pkg::sum_t'(ffha_pkg::HEAP_BYTES), "bump pointer past heap")
    `ASSERT_NEVER(a_one_cmd, ucmd.valid && fcmd.valid, "both tables commanded at once")
    `ASSERT_PROP(a_resp_src, $rose(m_valid_reg) |-> ($past(state_reg) == ffha_pkg::S_DONE), "response without finished request")

endmodule
`default_nettype wire

// ===== rtl/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffha_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/ffha_table.sv =====
// Start-sorted chunk table: insert, remove, write, scans and merge pass over one RAM.
`default_nettype none
`include "assert_macros.svh"
module ffha_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  ffha_pkg::tab_cmd_t cmd,
    output ffha_pkg::tab_rsp_t rsp,
    output ffha_pkg::cnt_t     count
);

    ffha_pkg::tab_state_t state_reg, state_next;
    ffha_pkg::cnt_t       cnt_reg, cnt_next;
    ffha_pkg::cnt_t       k_reg, k_next;
    ffha_pkg::cnt_t       w_reg, w_next;
    ffha_pkg::size_t      key_reg, key_next;
    ffha_pkg::tab_entry_t entry_reg, entry_next;
    logic                 find_reg, find_next;
    logic                 done_reg, done_next;
    logic                 hit_reg, hit_next;
    ffha_pkg::idx_t       idx_reg, idx_next;
    ffha_pkg::tab_entry_t rsp_entry_reg, rsp_entry_next;

    logic                 we;
    ffha_pkg::idx_t       waddr, raddr;
    ffha_pkg::tab_entry_t wdata, rdata;

    ffha_pkg::cnt_t k_m1, k_m2, k_p1, k_p2, cnt_m1, cmd_idx_p1, w_p1;
    logic           match, adjacent;

    assign k_m1       = k_reg - 1'b1;
    assign k_m2       = k_reg - 2'd2;
    assign k_p1       = k_reg + 1'b1;
    assign k_p2       = k_reg + 2'd2;
    assign cnt_m1     = cnt_reg - 1'b1;
    assign cmd_idx_p1 = ffha_pkg::cnt_t'(cmd.idx) + 1'b1;
    assign w_p1       = w_reg + 1'b1;

    assign match = find_reg ? (ffha_pkg::size_t'(rdata.start) == key_reg)
                            : (rdata.len >= key_reg);
    assign adjacent = (ffha_pkg::wide_t'(entry_reg.start) + ffha_pkg::wide_t'(entry_reg.len))
                      == ffha_pkg::wide_t'(rdata.start);

    ffha_ram #(
        .WIDTH(ffha_pkg::ENTRY_W),
        .DEPTH(ffha_pkg::TABLE_ENTRIES)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ffha_pkg::T_IDLE: begin
                if (cmd.valid) begin
                    unique case (cmd.op)
                        ffha_pkg::OP_INSERT:
                            state_next = (cnt_reg == '0) ? ffha_pkg::T_IDLE : ffha_pkg::T_INS;
                        ffha_pkg::OP_REMOVE:
                            state_next = (cmd_idx_p1 < cnt_reg) ? ffha_pkg::T_REM
                                                                : ffha_pkg::T_IDLE;
                        ffha_pkg::OP_FIT, ffha_pkg::OP_FIND:
                            state_next = (cnt_reg == '0) ? ffha_pkg::T_IDLE : ffha_pkg::T_SCAN;
                        ffha_pkg::OP_MERGE:
                            state_next = (cnt_reg < 2'd2) ? ffha_pkg::T_IDLE
                                                          : ffha_pkg::T_MERGE_FIRST;
                        default: state_next = ffha_pkg::T_IDLE;
                    endcase
                end
            end
            ffha_pkg::T_INS: begin
                if (rdata.start >= entry_reg.start) begin
                    state_next = (k_reg == 1'b1) ? ffha_pkg::T_INS_LAST : ffha_pkg::T_INS;
                end else begin
                    state_next = ffha_pkg::T_IDLE;
                end
            end
            ffha_pkg::T_INS_LAST: state_next = ffha_pkg::T_IDLE;
            ffha_pkg::T_REM:
                state_next = (k_p2 < cnt_reg) ? ffha_pkg::T_REM : ffha_pkg::T_IDLE;
            ffha_pkg::T_SCAN: begin
                if (match || !(k_p1 < cnt_reg)) begin
                    state_next = ffha_pkg::T_IDLE;
                end
            end
            ffha_pkg::T_MERGE_FIRST: state_next = ffha_pkg::T_MERGE;
            ffha_pkg::T_MERGE:
                state_next = (k_p1 < cnt_reg) ? ffha_pkg::T_MERGE : ffha_pkg::T_MERGE_END;
            ffha_pkg::T_MERGE_END: state_next = ffha_pkg::T_IDLE;
            default: state_next = ffha_pkg::T_IDLE;
        endcase
    end

    always_comb begin
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        w_next         = w_reg;
        key_next       = key_reg;
        entry_next     = entry_reg;
        find_next      = find_reg;
        done_next      = 1'b0;
        hit_next       = hit_reg;
        idx_next       = idx_reg;
        rsp_entry_next = rsp_entry_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = entry_reg;
        raddr          = '0;
        unique case (state_reg)
            ffha_pkg::T_IDLE: begin
                if (cmd.valid) begin
                    key_next   = cmd.key;
                    entry_next = cmd.entry;
                    find_next  = (cmd.op == ffha_pkg::OP_FIND);
                    hit_next   = 1'b0;
                    unique case (cmd.op)
                        ffha_pkg::OP_INSERT: begin
                            if (cnt_reg == '0) begin
                                we        = 1'b1;
                                wdata     = cmd.entry;
                                cnt_next  = cnt_reg + 1'b1;
                                done_next = 1'b1;
                            end else begin
                                k_next = cnt_reg;
                                raddr  = cnt_m1[ffha_pkg::IDX_W-1:0];
                            end
                        end
                        ffha_pkg::OP_REMOVE: begin
                            if (cmd_idx_p1 < cnt_reg) begin
                                raddr  = cmd_idx_p1[ffha_pkg::IDX_W-1:0];
                                k_next = ffha_pkg::cnt_t'(cmd.idx);
                            end else begin
                                cnt_next  = cnt_m1;
                                done_next = 1'b1;
                            end
                        end
                        ffha_pkg::OP_FIT, ffha_pkg::OP_FIND, ffha_pkg::OP_MERGE: begin
                            k_next = '0;
                            if ((cnt_reg == '0) ||
                                ((cmd.op == ffha_pkg::OP_MERGE) && (cnt_reg < 2'd2))) begin
                                done_next = 1'b1;
                            end
                        end
                        ffha_pkg::OP_WRITE: begin
                            we        = 1'b1;
                            waddr     = cmd.idx;
                            wdata     = cmd.entry;
                            done_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ffha_pkg::T_INS: begin
                // rdata holds entry k-1; shift it up while its start is not below the new one
                we    = 1'b1;
                waddr = k_reg[ffha_pkg::IDX_W-1:0];
                if (rdata.start >= entry_reg.start) begin
                    wdata  = rdata;
                    k_next = k_m1;
                    raddr  = k_m2[ffha_pkg::IDX_W-1:0];
                end else begin
                    cnt_next  = cnt_reg + 1'b1;
                    done_next = 1'b1;
                end
            end
            ffha_pkg::T_INS_LAST: begin
                we        = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                done_next = 1'b1;
            end
            ffha_pkg::T_REM: begin
                we     = 1'b1;
                waddr  = k_reg[ffha_pkg::IDX_W-1:0];
                wdata  = rdata;
                k_next = k_p1;
                raddr  = k_p2[ffha_pkg::IDX_W-1:0];
                if (!(k_p2 < cnt_reg)) begin
                    cnt_next  = cnt_m1;
                    done_next = 1'b1;
                end
            end
            ffha_pkg::T_SCAN: begin
                if (match) begin
                    done_next      = 1'b1;
                    hit_next       = 1'b1;
                    idx_next       = k_reg[ffha_pkg::IDX_W-1:0];
                    rsp_entry_next = rdata;
                end else if (k_p1 < cnt_reg) begin
                    raddr  = k_p1[ffha_pkg::IDX_W-1:0];
                    k_next = k_p1;
                end else begin
                    done_next = 1'b1;
                end
            end
            ffha_pkg::T_MERGE_FIRST: begin
                entry_next = rdata;
                raddr      = k_p1[ffha_pkg::IDX_W-1:0];
                k_next     = k_p1;
                w_next     = '0;
            end
            ffha_pkg::T_MERGE: begin
                // compaction: write side trails read side, so no overlap
                if (adjacent) begin
                    entry_next.len = entry_reg.len + rdata.len;
                end else begin
                    we         = 1'b1;
                    waddr      = w_reg[ffha_pkg::IDX_W-1:0];
                    w_next     = w_p1;
                    entry_next = rdata;
                end
                raddr  = k_p1[ffha_pkg::IDX_W-1:0];
                k_next = k_p1;
            end
            ffha_pkg::T_MERGE_END: begin
                we        = 1'b1;
                waddr     = w_reg[ffha_pkg::IDX_W-1:0];
                cnt_next  = w_p1;
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffha_pkg::T_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        w_reg         <= w_next;
        key_reg       <= key_next;
        entry_reg     <= entry_next;
        find_reg      <= find_next;
        hit_reg       <= hit_next;
        idx_reg       <= idx_next;
        rsp_entry_reg <= rsp_entry_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.hit   = hit_reg;
    assign rsp.idx   = idx_reg;
    assign rsp.entry = rsp_entry_reg;
    assign count     = cnt_reg;

    `ASSERT_PROP(a_cnt_bound, cnt_reg <= ffha_pkg::cnt_t'(ffha_pkg::TABLE_ENTRIES), "table count overflow")
    `ASSERT_PROP(a_cmd_idle, cmd.valid |-> (state_reg == ffha_pkg::T_IDLE), "command while busy")
    `ASSERT_PROP(a_merge_order, (state_reg == ffha_pkg::T_MERGE) |-> (w_reg < k_reg), "merge write overtakes read")

endmodule
`default_nettype wire

// ===== sim/tb_first_fit_heap_allocator_core.sv =====
// Self-checking testbench of the first-fit heap allocator core.
`default_nettype none
module tb_first_fit_heap_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 12000000;
    localparam int N_RANDOM = 1070;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ffha_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ffha_pkg::M_TDATA_W-1:0] m_tdata;

    first_fit_heap_allocator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    typedef struct packed {
        ffha_pkg::addr_t   address;
        ffha_pkg::status_t status;
    } reply_t;

    // allocator shadow state
    int unsigned bump;
    int unsigned used_st[$], used_ln[$], free_st[$], free_ln[$];
    reply_t pending_replies[$];
    int errors = 0;
    int cycles = 0;
    bit tail_phase = 0;

    task automatic report(input string what);
        $display("MISMATCH: %s", what);
        errors++;
    endtask

    function automatic void sorted_add(ref int unsigned st[$], ref int unsigned ln[$],
                                       input int unsigned s, input int unsigned n);
        int k;
        k = 0;
        while (k < st.size() && st[k] < s) k++;
        st.insert(k, s);
        ln.insert(k, n);
    endfunction

    function automatic bit first_fit(input int unsigned size, output int unsigned a);
        for (int i = 0; i < free_st.size(); i++) begin
            if (free_ln[i] >= size) begin
                a = free_st[i];
                sorted_add(used_st, used_ln, a, size);
                if (free_ln[i] == size) begin
                    free_st.delete(i);
                    free_ln.delete(i);
                end else begin
                    free_ln[i] -= size;
                    free_st[i] += size;
                end
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic reply_t allocator_step(input logic kind, input int unsigned size,
                                              input int unsigned faddr);
        reply_t r;
        int unsigned a;
        int idx;
        r.address = '0;
        r.status = ffha_pkg::ST_OK;
        a = 0;
        if (kind == ffha_pkg::KIND_ALLOC) begin
            if (size == 0) r.status = ffha_pkg::ST_ZERO;
            else if (used_st.size() >= ffha_pkg::TABLE_ENTRIES) r.status = ffha_pkg::ST_FULL;
            else if (bump + size <= ffha_pkg::HEAP_BYTES) begin
                sorted_add(used_st, used_ln, bump, size);
                r.address = ffha_pkg::addr_t'(bump);
                bump += size;
            end else begin
                if (!first_fit(size, a)) begin
                    int i;
                    i = 0;
                    while (i + 1 < free_st.size()) begin
                        if (free_st[i] + free_ln[i] == free_st[i+1]) begin
                            free_ln[i] += free_ln[i+1];
                            free_st.delete(i+1);
                            free_ln.delete(i+1);
                        end else i++;
                    end
                    if (!first_fit(size, a)) r.status = ffha_pkg::ST_NOSPACE;
                end
                if (r.status == ffha_pkg::ST_OK) r.address = ffha_pkg::addr_t'(a);
            end
        end else begin
            idx = -1;
            foreach (used_st[i]) if (idx < 0 && used_st[i] == faddr) idx = i;
            if (idx < 0) r.status = ffha_pkg::ST_NOTFOUND;
            else if (free_st.size() >= ffha_pkg::TABLE_ENTRIES) r.status = ffha_pkg::ST_FULL;
            else begin
                sorted_add(free_st, free_ln, used_st[idx], used_ln[idx]);
                used_st.delete(idx);
                used_ln.delete(idx);
            end
        end
        return r;
    endfunction

    // sends one request; typed expectation used when chk is set
    task automatic send_request(input logic kind, input int unsigned size,
                                input int unsigned faddr, input bit chk,
                                input reply_t typed);
        reply_t r;
        if (!tail_phase && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        r = allocator_step(kind, size, faddr);
        if (chk && r != typed) report($sformatf("typed row disagrees: %h vs %h", r, typed));
        pending_replies.push_back(r);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {7'b0, faddr[15:0], size[16:0]};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic int unsigned random_size();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 65536);
            1: return 0;
            2: return $urandom_range(1024, 8192);
            default: return $urandom_range(1, 600);
        endcase
    endfunction

    function automatic int unsigned random_free_addr();
        if (used_st.size() > 0 && $urandom_range(0, 9) < 8)
            return used_st[$urandom_range(0, used_st.size() - 1)];
        return $urandom_range(0, 65535);
    endfunction

    // response checker
    always @(posedge aclk) begin
        reply_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.address = m_tdata[15:0];
            got.status = ffha_pkg::status_t'(m_tdata[18:16]);
            if (pending_replies.size() == 0) report("response with no request pending");
            else begin
                want = pending_replies.pop_front();
                if (got.address !== want.address)
                    report($sformatf("address %h expected %h", got.address, want.address));
                if (got.status !== want.status)
                    report($sformatf("status %0d expected %0d", got.status, want.status));
            end
        end
    end

    // sink stalls
    always @(negedge aclk) begin
        int stall;
        if (!tail_phase && $urandom_range(0, 6) == 0) begin
            stall = $urandom_range(1, 11);
            m_tready <= 1'b0;
            repeat (stall - 1) @(negedge aclk);
        end else m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    typedef struct {
        logic kind;
        int unsigned size;
        int unsigned faddr;
        bit chk;
        reply_t want;
    } row_t;

    row_t table_rows[$];

    initial begin
        bump = 0;
        table_rows = '{
            '{ffha_pkg::KIND_FREE, 0, 0, 1, '{16'd0, ffha_pkg::ST_NOTFOUND}},
            '{ffha_pkg::KIND_ALLOC, 0, 0, 1, '{16'd0, ffha_pkg::ST_ZERO}},
            '{ffha_pkg::KIND_ALLOC, 1, 0, 1, '{16'd0, ffha_pkg::ST_OK}},
            '{ffha_pkg::KIND_ALLOC, 65535, 0, 1, '{16'd1, ffha_pkg::ST_OK}},
            '{ffha_pkg::KIND_ALLOC, 1, 0, 1, '{16'd0, ffha_pkg::ST_NOSPACE}},
            '{ffha_pkg::KIND_FREE, 0, 65535, 1, '{16'd0, ffha_pkg::ST_NOTFOUND}},
            '{ffha_pkg::KIND_FREE, 131071, 1, 1, '{16'd0, ffha_pkg::ST_OK}},
            '{ffha_pkg::KIND_FREE, 0, 0, 1, '{16'd0, ffha_pkg::ST_OK}},
            '{ffha_pkg::KIND_FREE, 0, 0, 1, '{16'd0, ffha_pkg::ST_NOTFOUND}},
            '{ffha_pkg::KIND_ALLOC, 65536, 0, 0, '{16'd0, ffha_pkg::ST_OK}},
            '{ffha_pkg::KIND_ALLOC, 65536, 0, 1, '{16'd0, ffha_pkg::ST_NOSPACE}},
            '{ffha_pkg::KIND_FREE, 0, 0, 0, '{16'd0, ffha_pkg::ST_OK}},
            '{ffha_pkg::KIND_ALLOC, 100, 0, 0, '{16'd0, ffha_pkg::ST_OK}},
            '{ffha_pkg::KIND_ALLOC, 65436, 0, 0, '{16'd0, ffha_pkg::ST_OK}},
            '{ffha_pkg::KIND_FREE, 0, 100, 0, '{16'd0, ffha_pkg::ST_OK}},
            '{ffha_pkg::KIND_ALLOC, 131071, 0, 0, '{16'd0, ffha_pkg::ST_OK}},
            '{ffha_pkg::KIND_ALLOC, 65435, 0, 0, '{16'd0, ffha_pkg::ST_OK}},
            '{ffha_pkg::KIND_FREE, 0, 0, 0, '{16'd0, ffha_pkg::ST_OK}}
        };
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (table_rows[i])
            send_request(table_rows[i].kind, table_rows[i].size, table_rows[i].faddr,
                         table_rows[i].chk, table_rows[i].want);
        // allocate tiny blocks until the heap has no space left
        for (int i = 0; i < 260; i++) send_request(ffha_pkg::KIND_ALLOC, 1, 0, 0, '0);
        // free every used block into the free table
        for (int i = 0; i < 262 && used_st.size() > 0; i++)
            send_request(ffha_pkg::KIND_FREE, 0, used_st[0], 0, '0);
        // fragmented reuse
        for (int i = 0; i < 40; i++)
            send_request(ffha_pkg::KIND_ALLOC, $urandom_range(1, 3), 0, 0, '0);
        s_tvalid <= 1'b0;
        wait (pending_replies.size() == 0);
        @(negedge aclk);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i > N_RANDOM - 150) tail_phase = 1;
            if ($urandom_range(0, 1)) send_request(ffha_pkg::KIND_ALLOC, random_size(),
                                                  $urandom_range(0, 65535), 0, '0);
            else send_request(ffha_pkg::KIND_FREE, $urandom_range(0, 131071),
                              random_free_addr(), 0, '0);
        end
        tail_phase = 1;
        s_tvalid <= 1'b0;
        wait (pending_replies.size() == 0);
        repeat (1400) @(posedge aclk);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
